[sv/nrte_pkg.sv]
package nrte_pkg;

   // Line framing
   localparam int LINE_BYTES = 256;
   localparam int LINE_POS_W = $clog2(LINE_BYTES);

   localparam int HOURS_PER_DAY     = 24;
   localparam logic [4:0] ZONE_RESET = 5'd8;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NUL     = 8'h00;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_error;
   } req_type;

   typedef struct packed {
      logic [4:0] local_hours;
      logic [6:0] time_minutes;
      logic [6:0] time_seconds;
   } rsp_type;

   // Parser to output stage
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // Characters of the "$GNRMC" tag
   function automatic logic [7:0] tag_char(input logic [2:0] i);
      logic [7:0] ch;
      case (i)
         3'd0:    ch = CHAR_DOLLAR;
         3'd1:    ch = 8'h47;  // G
         3'd2:    ch = 8'h4E;  // N
         3'd3:    ch = 8'h52;  // R
         3'd4:    ch = 8'h4D;  // M
         3'd5:    ch = 8'h43;  // C
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {[8'h09:8'h0D], 8'h20};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   // Value below 192 reduced modulo 24 by restoring subtraction
   function automatic logic [4:0] mod24(input logic [7:0] v);
      logic [7:0] t;
      t = v;
      if (t >= 8'(4 * HOURS_PER_DAY)) t = t - 8'(4 * HOURS_PER_DAY);
      if (t >= 8'(2 * HOURS_PER_DAY)) t = t - 8'(2 * HOURS_PER_DAY);
      if (t >= 8'(HOURS_PER_DAY))     t = t - 8'(HOURS_PER_DAY);
      return t[4:0];
   endfunction

endpackage

[sv/nrte_line_parser.sv]
module nrte_line_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  nrte_pkg::req_type    req,
   input  logic [4:0]           zone_offset,
   output nrte_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_MATCH0, PH_MATCH1, PH_MATCH2, PH_MATCH3, PH_MATCH4, PH_MATCH5,
      PH_SKIP, PH_FIELD0, PH_FIELD1, PH_FIELD2, PH_DONE, PH_FAIL
   } phase_type;

   logic [nrte_pkg::LINE_POS_W-1:0] pos_ff, pos_in;
   phase_type  phase_ff, phase_in;
   logic       digit_ff, digit_in;
   logic [6:0] hour_ff, hour_in;
   logic [6:0] min_ff, min_in;
   logic [6:0] sec_ff, sec_in;
   logic       ended_ff, ended_in;

   logic [7:0] c;
   logic [1:0] idx;
   logic       cont;
   logic [6:0] cap_cur;
   logic       wr_en;
   logic [1:0] wr_idx;
   logic [6:0] wr_val;
   logic       end_line;
   logic       line_ok;

   assign c = req.rx_byte;

   always_comb begin
      case (idx)
         2'd0:    cap_cur = hour_ff;
         2'd1:    cap_cur = min_ff;
         default: cap_cur = sec_ff;
      endcase
   end

   always_comb begin
      pos_in   = pos_ff + nrte_pkg::LINE_POS_W'(1);
      phase_in = phase_ff;
      digit_in = digit_ff;
      ended_in = ended_ff;
      idx      = 2'd0;
      cont     = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = 2'd0;
      wr_val   = 7'd0;

      if (!ended_ff && phase_ff < PH_DONE) begin
         if (c == nrte_pkg::CHAR_NUL) begin
            ended_in = 1'b1;
         end else if (phase_ff < PH_SKIP) begin
            if (c == nrte_pkg::tag_char(phase_ff[2:0])) begin
               phase_in = phase_type'(4'(phase_ff) + 4'd1);
            end else begin
               phase_in = (c == nrte_pkg::CHAR_DOLLAR) ? PH_MATCH1 : PH_MATCH0;
            end
         end else if (phase_ff == PH_SKIP) begin
            phase_in = PH_FIELD0;
            digit_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_FIELD0: idx = 2'd0;
               PH_FIELD1: idx = 2'd1;
               default:   idx = 2'd2;
            endcase
            cont = 1'b1;
            // one digit held: this byte either completes the field or opens the next
            if (digit_ff) begin
               digit_in = 1'b0;
               phase_in = phase_type'(4'(phase_ff) + 4'd1);
               if (nrte_pkg::is_digit(c)) begin
                  wr_en  = 1'b1;
                  wr_idx = idx;
                  wr_val = 7'(11'(cap_cur) * 11'd10 + 11'(c - nrte_pkg::CHAR_ZERO));
                  cont   = 1'b0;
               end else if (phase_ff == PH_FIELD2) begin
                  cont = 1'b0;
               end
            end
            if (cont) begin
               if (nrte_pkg::is_space(c)) begin
                  // leading whitespace
               end else if (nrte_pkg::is_digit(c)) begin
                  wr_en    = 1'b1;
                  wr_idx   = (digit_ff) ? idx + 2'd1 : idx;
                  wr_val   = 7'(c - nrte_pkg::CHAR_ZERO);
                  digit_in = 1'b1;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end
      end
   end

   always_comb begin
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      if (wr_en) begin
         case (wr_idx)
            2'd0:    hour_in = wr_val;
            2'd1:    min_in  = wr_val;
            default: sec_in  = wr_val;
         endcase
      end
   end

   assign end_line = (c == nrte_pkg::CHAR_NEWLINE) ||
                     (pos_in == nrte_pkg::LINE_POS_W'(nrte_pkg::LINE_BYTES - 1));
   assign line_ok  = (phase_in == PH_DONE) || (phase_in == PH_FIELD2 && digit_in);

   // hour field is settled long before the line can qualify
   assign result.valid             = accept && !req.rx_error && end_line && line_ok;
   assign result.data.local_hours  = nrte_pkg::mod24(8'(hour_ff) + 8'(zone_offset));
   assign result.data.time_minutes = min_in;
   assign result.data.time_seconds = sec_in;

   always_ff @(posedge clock) begin
      if (reset || (accept && (req.rx_error || end_line))) begin
         pos_ff   <= '0;
         phase_ff <= PH_MATCH0;
         digit_ff <= 1'b0;
         hour_ff  <= 7'd0;
         min_ff   <= 7'd0;
         sec_ff   <= 7'd0;
         ended_ff <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         digit_ff <= digit_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         ended_ff <= ended_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff != nrte_pkg::LINE_POS_W'(nrte_pkg::LINE_BYTES - 1))
      else $error("line position reached the frame limit");

   a_error_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req.rx_error |=> pos_ff == '0 && phase_ff == PH_MATCH0 && !digit_ff)
      else $error("receiver error did not discard the line");

endmodule

[sv/nmea_rmc_time_extractor_unit.sv]
// Channel   Direction  Payload               Handshake
// req_      in         nrte_pkg::req_type    req_valid / req_stall
// rsp_      out        nrte_pkg::rsp_type    rsp_valid / rsp_stall
// csr_      in         zone offset, 5 bits   csr_wr_en (write only)
//
// One item is accepted per clock while req_stall is low; each byte is parsed in a
// single combinational pass. A line's result is registered in the output or skid register.
// Output register plus one skid entry: req_stall rises only while the skid entry is full.
// Synchronous active-high reset clears line state; zone offset resets to 8.
module nmea_rmc_time_extractor_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nrte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nrte_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);

   logic [4:0]           zone_ff;
   logic                 out_valid_ff;
   nrte_pkg::rsp_type    out_data_ff;
   logic                 skid_valid_ff;
   nrte_pkg::rsp_type    skid_data_ff;
   nrte_pkg::result_type result;
   logic                 accept;
   logic                 rsp_fire;

   // the skid entry guarantees room for whatever the accepted byte produces
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   nrte_line_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .zone_offset (zone_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= nrte_pkg::ZONE_RESET;
      end else if (csr_wr_en) begin
         zone_ff <= csr_wr_data;
      end
   end

   // Output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || rsp_fire) begin
            out_data_ff  <= result.data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= result.data;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds an item while the output register is empty");

   a_stalled_result_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall && !skid_valid_ff && result.valid |=> skid_valid_ff)
      else $error("result produced under output stall was not kept");

endmodule
